### design/aabs_pkg.sv
// ----------------------------------------------------------------------------
// aabs_pkg: shared types for the bounding box and sphere block
// Command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package aabs_pkg;

  typedef struct packed {
    logic take;
    logic center;
    logic scan;
    logic root_start;
    logic root_step;
    logic out_load;
  } aabs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_final;
    logic scan_last;
    logic pipe_busy;
    logic root_last;
    logic out_busy;
  } aabs_stat_t;

endpackage

### design/aabs_if.sv
// ----------------------------------------------------------------------------
// aabs_if: point and result channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface aabs_in_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         final_point;

  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface aabs_out_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] low_x;
  logic signed [COORD_BITS-1:0] low_y;
  logic signed [COORD_BITS-1:0] low_z;
  logic signed [COORD_BITS-1:0] high_x;
  logic signed [COORD_BITS-1:0] high_y;
  logic signed [COORD_BITS-1:0] high_z;
  logic signed [COORD_BITS:0]   center2_x;
  logic signed [COORD_BITS:0]   center2_y;
  logic signed [COORD_BITS:0]   center2_z;
  logic        [COORD_BITS+1:0] radius2;
  logic                         store_overflow;

  modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  center2_x, center2_y, center2_z, radius2, store_overflow,
                  input ready);
  modport sink   (input valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  center2_x, center2_y, center2_z, radius2, store_overflow,
                  output ready);
endinterface

### design/aabs_ctrl.sv
// ----------------------------------------------------------------------------
// aabs_ctrl: sequencer for load, scan, square root and result hand-off
// One-hot state machine driving the datapath through command signals.
// ----------------------------------------------------------------------------
module aabs_ctrl import aabs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  aabs_stat_t st,
  output aabs_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_CENTER = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_ROOT   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.take = 1'b1;
        if (st.in_valid && st.in_final) state_nxt = S_CENTER;
      end
      S_CENTER: begin
        cmd.center = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!st.pipe_busy) begin
          cmd.root_start = 1'b1;
          state_nxt      = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (st.root_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/aabs_dp.sv
// ----------------------------------------------------------------------------
// aabs_dp: point store, running box, distance pipeline and square root
// Stores points, tracks min/max, scans for the largest squared distance
// and takes its integer root one bit a cycle.
// ----------------------------------------------------------------------------
module aabs_dp import aabs_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aabs_in_if.sink    in_ch,
  aabs_out_if.source out_ch,
  input  aabs_cmd_t  cmd,
  output aabs_stat_t st
);

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 3 * CB;
  localparam int RW = CB + 1;
  localparam int SW = 2 * RW;
  localparam int IW = $clog2(RW);
  localparam logic signed [CB-1:0] TOP_C = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] BOT_C = {1'b1, {(CB-1){1'b0}}};

  logic [PW-1:0] mem [MAX_POINTS];

  logic        [CW-1:0] count_r;
  logic signed [CB-1:0] low_r  [3];
  logic signed [CB-1:0] high_r [3];
  logic                 ovf_r;
  logic signed [CB:0]   c2_r   [3];
  logic        [AW-1:0] addr_r;
  logic        [PW-1:0] rd_r;
  logic                 v1_r, v2_r, v3_r;
  logic        [CB-1:0] mag_r  [3];
  logic      [2*CB-1:0] sq_r   [3];
  logic        [SW-1:0] max_r;
  logic        [SW-1:0] num_r;
  logic          [RW:0] rem_r;
  logic        [RW-1:0] root_r;
  logic        [IW-1:0] it_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 room;
  logic signed [CB-1:0] pt   [3];
  logic signed [CB+1:0] diff [3];
  logic        [CB+1:0] absd [3];
  logic        [SW-1:0] sum;
  logic        [RW+2:0] trial_ext, trial_sub, trial_diff;

  assign accept = in_ch.valid && cmd.take;
  assign room   = count_r < CW'(MAX_POINTS);
  assign pt[0]  = in_ch.point_x;
  assign pt[1]  = in_ch.point_y;
  assign pt[2]  = in_ch.point_z;
  assign in_ch.ready = cmd.take;

  // running box and fill count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        low_r[a]  <= TOP_C;
        high_r[a] <= BOT_C;
      end
    end else if (accept) begin
      if (room) count_r <= count_r + CW'(1);
      else      ovf_r   <= 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (pt[a] < low_r[a])  low_r[a]  <= pt[a];
        if (pt[a] > high_r[a]) high_r[a] <= pt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) mem[count_r[AW-1:0]] <= {pt[2], pt[1], pt[0]};
    if (cmd.scan) rd_r <= mem[addr_r];
  end

  // doubled center and scan address
  always_ff @(posedge clk) begin
    if (cmd.center) begin
      for (int a = 0; a < 3; a++) begin
        c2_r[a] <= {low_r[a][CB-1], low_r[a]} + {high_r[a][CB-1], high_r[a]};
      end
      addr_r <= '0;
    end else if (cmd.scan) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = $signed({rd_r[a*CB+CB-1], rd_r[a*CB +: CB], 1'b0})
              - $signed({c2_r[a][CB], c2_r[a]});
      absd[a] = diff[a][CB+1] ? (CB+2)'(-diff[a]) : diff[a];
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      for (int a = 0; a < 3; a++) mag_r[a] <= absd[a][CB-1:0];
    end
    if (v2_r) begin
      for (int a = 0; a < 3; a++) sq_r[a] <= mag_r[a] * mag_r[a];
    end
  end

  assign sum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.center) begin
      max_r <= '0;
    end else if (v3_r && (sum > max_r)) begin
      max_r <= sum;
    end
  end

  // digit-by-digit square root, one result bit per cycle
  assign trial_ext  = {rem_r, num_r[SW-1:SW-2]};
  assign trial_sub  = {1'b0, root_r, 2'b01};
  assign trial_diff = trial_ext - trial_sub;

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      num_r  <= max_r;
      rem_r  <= '0;
      root_r <= '0;
      it_r   <= '0;
    end else if (cmd.root_step) begin
      num_r <= {num_r[SW-3:0], 2'b00};
      it_r  <= it_r + IW'(1);
      if (trial_ext >= trial_sub) begin
        rem_r  <= trial_diff[RW:0];
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= trial_ext[RW:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.low_x          <= low_r[0];
      out_ch.low_y          <= low_r[1];
      out_ch.low_z          <= low_r[2];
      out_ch.high_x         <= high_r[0];
      out_ch.high_y         <= high_r[1];
      out_ch.high_z         <= high_r[2];
      out_ch.center2_x      <= c2_r[0];
      out_ch.center2_y      <= c2_r[1];
      out_ch.center2_z      <= c2_r[2];
      out_ch.radius2        <= {1'b0, root_r};
      out_ch.store_overflow <= ovf_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  assign st.in_valid  = in_ch.valid;
  assign st.in_final  = in_ch.final_point;
  assign st.scan_last = CW'(addr_r) == (count_r - CW'(1));
  assign st.pipe_busy = v1_r || v2_r || v3_r;
  assign st.root_last = it_r == IW'(RW - 1);
  assign st.out_busy  = out_valid_r && !out_ch.ready;

endmodule

### design/aabb_and_bounding_sphere.sv
// ----------------------------------------------------------------------------
// aabb_and_bounding_sphere: box and box-centered sphere of a point set
// Collects a point set, reports its per-axis box, doubled center and
// doubled radius, and flags points that did not fit in the store.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    point_x, point_y, point_z, final_point
//  out_ch   out  valid/ready    low_*, high_*, center2_*, radius2, store_overflow
//
//  points are taken one per cycle while the block is in its load state;
//  after the final point it steps in turn through center, store scan,
//  distance pipeline drain and the bit-serial root, then loads the result
//  register. the store read port sets the scan rate at one point a cycle.
//  rst_n is synchronous; the store itself needs no clearing.
//  a held result stalls the next set's hand-off, and point intake with it.
// ----------------------------------------------------------------------------
module aabb_and_bounding_sphere import aabs_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aabs_in_if.sink    in_ch,
  aabs_out_if.source out_ch
);

  aabs_cmd_t  cmd;
  aabs_stat_t st;

  aabs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  aabs_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .st     (st)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register loaded while a result is pending");

  a_stop_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.final_point) |=> !in_ch.ready)
    else $error("point taken right after the final point");

  a_root_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_start |-> !st.pipe_busy && !cmd.scan)
    else $error("root started with distances still in flight");

  a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !out_ch.radius2[COORD_BITS+1])
    else $error("radius out of range");
`endif

endmodule

### tb/tb_aabb_and_bounding_sphere.sv
// ----------------------------------------------------------------------------
// tb_aabb_and_bounding_sphere: self-checking bench for the box and sphere block
// Streams point sets through the point channel, predicts each set's box,
// doubled center, doubled radius and overflow flag, and compares every
// result item field by field. A short table of hand-picked sets comes first,
// then random sets of mixed shape, one set that overruns the point store,
// random gaps on both channels and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_aabb_and_bounding_sphere;

  localparam int COORD_BITS       = 16;
  localparam int MAX_POINTS       = 1024;
  localparam int TARGET_ITEMS     = 1950;
  localparam int DIR_ROWS         = 20;
  localparam int GAP_MAX          = 18;
  localparam int RESET_CYCLES     = 12;
  localparam int SINK_HOLD_CYCLES = 600;
  localparam int PRESSURE_SETS    = 8;
  localparam int DRAIN_CYCLES     = COORD_BITS + 70;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int REPORT_LINES     = 40;
  localparam longint COORD_TOP    = 32767;
  localparam longint COORD_BOTTOM = -32768;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   center_t;
  typedef logic        [COORD_BITS+1:0] root_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t  low_x;
    coord_t  low_y;
    coord_t  low_z;
    coord_t  high_x;
    coord_t  high_y;
    coord_t  high_z;
    center_t center2_x;
    center_t center2_y;
    center_t center2_z;
    root_t   radius2;
    logic    store_overflow;
  } sphere_box_t;

  typedef struct packed {
    point_t      pt;
    logic        last;
    logic        known;
    sphere_box_t want;
  } point_row_t;

  typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_CORNERS} spread_t;

  localparam coord_t  CRD_MIN = 16'sh8000;
  localparam coord_t  CRD_MAX = 16'sh7fff;
  localparam center_t CTR_MIN = 17'sh10000;
  localparam center_t CTR_MAX = 17'sh0fffe;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  aabs_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  aabs_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  aabb_and_bounding_sphere #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  point_row_t  dir_rows [DIR_ROWS];
  sphere_box_t pending_boxes [$];
  point_t      kept_points [$];
  coord_t      span_lo [3];
  coord_t      span_hi [3];
  logic        spilled;

  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  bit sink_hold_req = 1'b0;

  int fail_count = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int set_len = 0;
  int largest_set = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int cycle_count = 0;

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= REPORT_LINES)
      $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic void restart_set();
    kept_points.delete();
    for (int a = 0; a < 3; a++) begin
      span_lo[a] = CRD_MAX;
      span_hi[a] = CRD_MIN;
    end
    spilled = 1'b0;
  endfunction

  function automatic root_t floor_root(longint n);
    longint r;
    longint t;
    r = 0;
    for (int b = COORD_BITS + 1; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n)
        r = t;
    end
    return root_t'(r);
  endfunction

  // widens the running box; on the last point builds the set's result
  function automatic bit take_point(point_t p, logic last, output sphere_box_t box);
    coord_t c [3];
    longint c2 [3];
    longint d;
    longint dist_sq;
    longint widest;
    box = '0;
    c[0] = p.x;
    c[1] = p.y;
    c[2] = p.z;
    if (kept_points.size() < MAX_POINTS)
      kept_points.push_back(p);
    else
      spilled = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (c[a] < span_lo[a])
        span_lo[a] = c[a];
      if (c[a] > span_hi[a])
        span_hi[a] = c[a];
    end
    if (!last)
      return 1'b0;
    for (int a = 0; a < 3; a++)
      c2[a] = longint'(span_lo[a]) + longint'(span_hi[a]);
    widest = 0;
    foreach (kept_points[i]) begin
      d = 2 * longint'(kept_points[i].x) - c2[0];
      dist_sq = d * d;
      d = 2 * longint'(kept_points[i].y) - c2[1];
      dist_sq += d * d;
      d = 2 * longint'(kept_points[i].z) - c2[2];
      dist_sq += d * d;
      if (dist_sq > widest)
        widest = dist_sq;
    end
    box = '{span_lo[0], span_lo[1], span_lo[2], span_hi[0], span_hi[1], span_hi[2],
            center_t'(c2[0]), center_t'(c2[1]), center_t'(c2[2]),
            floor_root(widest), spilled};
    restart_set();
    return 1'b1;
  endfunction

  function automatic coord_t pick_coord(spread_t s, coord_t anchor);
    longint v;
    case (s)
      SPREAD_CLUSTER: begin
        v = longint'(anchor) + longint'($urandom_range(0, 80)) - 40;
        if (v > COORD_TOP)
          v = COORD_TOP;
        if (v < COORD_BOTTOM)
          v = COORD_BOTTOM;
        return coord_t'(v);
      end
      SPREAD_CORNERS: begin
        case ($urandom_range(0, 3))
          0: return CRD_MIN;
          1: return CRD_MAX;
          2: return '0;
          default: return -16'sd1;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic offer_point(point_t p, logic last, logic known, sphere_box_t typed_box);
    int gap;
    sphere_box_t box;
    gap = src_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.point_x     <= p.x;
    in_ch.point_y     <= p.y;
    in_ch.point_z     <= p.z;
    in_ch.final_point <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    set_len++;
    if (take_point(p, last, box)) begin
      pending_boxes.push_back(known ? typed_box : box);
      sets_sent++;
      if (set_len > largest_set)
        largest_set = set_len;
      set_len = 0;
    end
  endtask

  // result side: random stalls per item, one long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0)
        sink_burst = !sink_burst;
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      stall = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : result_check
    sphere_box_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch("result item with no set pending");
      end else begin
        want = pending_boxes.pop_front();
        check_field("low_x", out_ch.low_x, want.low_x);
        check_field("low_y", out_ch.low_y, want.low_y);
        check_field("low_z", out_ch.low_z, want.low_z);
        check_field("high_x", out_ch.high_x, want.high_x);
        check_field("high_y", out_ch.high_y, want.high_y);
        check_field("high_z", out_ch.high_z, want.high_z);
        check_field("center2_x", out_ch.center2_x, want.center2_x);
        check_field("center2_y", out_ch.center2_y, want.center2_y);
        check_field("center2_z", out_ch.center2_z, want.center2_z);
        check_field("radius2", out_ch.radius2, want.radius2);
        check_field("store_overflow", out_ch.store_overflow, want.store_overflow);
        results_checked++;
        if (out_ch.store_overflow)
          overflow_results++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d sets still pending", cycle_count,
             pending_boxes.size());
    $display("aabb_and_bounding_sphere verification failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    int set_idx;
    int big_at;
    spread_t spread;
    point_t anchor;
    point_t p;
    in_ch.valid       = 1'b0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.point_z     = '0;
    in_ch.final_point = 1'b0;
    restart_set();

    dir_rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          17'sd0, 17'sd0, 17'sd0, 18'd0, 1'b0}},
      '{'{CRD_MIN, CRD_MIN, CRD_MIN}, 1'b1, 1'b1,
        '{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
          CTR_MIN, CTR_MIN, CTR_MIN, 18'd0, 1'b0}},
      '{'{CRD_MAX, CRD_MAX, CRD_MAX}, 1'b1, 1'b1,
        '{CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
          CTR_MAX, CTR_MAX, CTR_MAX, 18'd0, 1'b0}},
      '{'{CRD_MAX, CRD_MIN, 16'sd0}, 1'b1, 1'b1,
        '{CRD_MAX, CRD_MIN, 16'sd0, CRD_MAX, CRD_MIN, 16'sd0,
          CTR_MAX, CTR_MIN, 17'sd0, 18'd0, 1'b0}},
      // widest possible box
      '{'{CRD_MIN, CRD_MAX, CRD_MIN}, 1'b0, 1'b0, '0},
      '{'{CRD_MAX, CRD_MIN, CRD_MAX}, 1'b1, 1'b0, '0},
      '{'{16'sd5, 16'sd5, 16'sd5}, 1'b0, 1'b0, '0},
      '{'{16'sd5, 16'sd5, 16'sd5}, 1'b1, 1'b1,
        '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
          17'sd10, 17'sd10, 17'sd10, 18'd0, 1'b0}},
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0, '0},
      '{'{16'sd2, 16'sd0, 16'sd0}, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0,
          17'sd2, 17'sd0, 17'sd0, 18'd2, 1'b0}},
      '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, 1'b0, '0},
      '{'{16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, 1'b0, '0},
      '{'{16'sd0, -16'sd1, 16'sd0}, 1'b0, 1'b0, '0},
      '{'{-16'sd1, 16'sd0, -16'sd1}, 1'b1, 1'b0, '0},
      '{'{16'sd100, -16'sd200, 16'sd300}, 1'b0, 1'b0, '0},
      '{'{-16'sd5, 16'sd7, 16'sd0}, 1'b0, 1'b0, '0},
      '{'{16'sd12345, -16'sd12345, 16'sd1}, 1'b1, 1'b0, '0},
      '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, 1'b0, '0},
      '{'{16'sd1, 16'sd1, 16'sd1}, 1'b1, 1'b1,
        '{-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1,
          17'sd0, 17'sd0, 17'sd0, 18'd3, 1'b0}},
      '{'{CRD_MIN, 16'sd0, CRD_MAX}, 1'b1, 1'b1,
        '{CRD_MIN, 16'sd0, CRD_MAX, CRD_MIN, 16'sd0, CRD_MAX,
          CTR_MIN, 17'sd0, CTR_MAX, 18'd0, 1'b0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      offer_point(dir_rows[i].pt, dir_rows[i].last, dir_rows[i].known, dir_rows[i].want);

    // hold results back while sets stream in back to back
    sink_hold_req = 1'b1;
    src_burst = 1'b1;
    big_at = $urandom_range(PRESSURE_SETS + 10, PRESSURE_SETS + 50);
    set_idx = 0;
    while (items_sent < TARGET_ITEMS || set_idx <= big_at) begin
      if (set_idx == PRESSURE_SETS)
        src_burst = 1'b0;
      if (set_idx == big_at)
        n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 6);
      else if ($urandom_range(0, 9) == 0)
        n = $urandom_range(13, 48);
      else
        n = $urandom_range(1, 12);
      spread = spread_t'($urandom_range(0, 2));
      anchor = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
      if ($urandom_range(0, 3) == 0)
        anchor = '{CRD_MAX, CRD_MIN, CRD_MAX};
      for (int k = 0; k < n; k++) begin
        p.x = pick_coord(spread, anchor.x);
        p.y = pick_coord(spread, anchor.y);
        p.z = pick_coord(spread, anchor.z);
        offer_point(p, k == n - 1, 1'b0, '0);
        if (set_idx >= PRESSURE_SETS && $urandom_range(0, 39) == 0)
          src_burst = !src_burst;
      end
      set_idx++;
    end
    in_ch.valid <= 1'b0;

    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d points in %0d sets (largest %0d points), checked %0d results",
             items_sent, sets_sent, largest_set, results_checked);
    $display("%0d results flagged store overflow, %0d mismatches, %0d cycles",
             overflow_results, fail_count, cycle_count);
    if (fail_count == 0)
      $display("aabb_and_bounding_sphere verification clean");
    else
      $display("aabb_and_bounding_sphere verification failed");
    $finish;
  end

endmodule

### filelist.f
design/aabs_pkg.sv
design/aabs_if.sv
design/aabs_ctrl.sv
design/aabs_dp.sv
design/aabb_and_bounding_sphere.sv
tb/tb_aabb_and_bounding_sphere.sv
